// File: rtl/core/assert_macros.svh
// Assertion macros shared by the descrambler RTL.
// Files that check their own logic include this header; it needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define XKD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xkd assertion failed");

// Check a property on every clock edge, reset included.
`define XKD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("xkd assertion failed");

`endif

// File: rtl/core/xkd_pkg.sv
// Package for the xorshift keystream descrambler: constants, command and control types.
// No dependencies; every other RTL file uses it by scoped names.
`timescale 1ns / 1ps

package xkd_pkg;

    // Action codes carried on the input channel
    localparam logic ACT_SEED = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    localparam logic [31:0] SEED_MASK = 32'h550f0f55;
    localparam logic [31:0] EXP_C1    = 32'h159a55e5;
    localparam logic [31:0] EXP_C2    = 32'h1f123bb5;
    localparam logic [31:0] EXP_C3    = 32'h05491333;
    localparam logic [31:0] EXP_C4    = 32'h34dad465;

    localparam int unsigned GEN_WORDS = 5;
    localparam int unsigned SH_U_R    = 7;
    localparam int unsigned SH_U_L    = 13;
    localparam int unsigned SH_W_L    = 6;

    // Low bits of the first draw give the discard count
    localparam int unsigned SKIP_W = 4;

    localparam int unsigned QUEUE_DEPTH = 2;

    // Classified command handed from front to back
    typedef struct packed {
        logic        is_seed;
        logic [31:0] seed;      // trailer word already XORed with SEED_MASK
        logic [7:0]  data_byte;
        logic        last;
    } cmd_t;

    // Generator control from the back sequencer
    typedef struct packed {
        logic load;
        logic step;
    } gen_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_DRAW,
        ST_SEED_CNT,
        ST_SKIP,
        ST_DATA_XOR
    } back_state_t;

endpackage

// File: rtl/core/xorshift_keystream_descrambler_unit.sv
// Top level of the xorshift keystream descrambler.
// Depends on xkd_pkg, xkd_front, xkd_back (which holds xkd_keygen).
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_ready  | action, seed_word, in_byte, in_last
//   output  | out_valid / out_ready| out_byte, out_last
//
// Back end: a data beat at an odd position goes straight to the output register;
// one at an even position steps the generator, then the registered multiply feeds
// the XOR. A seed beat loads the generator words and draws one word whose low bits
// give the discard count n (0..15), then discards n words, one step per cycle.
// The front queue takes beats while the back end is busy.
// Reset: rst_n clears the queue, the generator words to zero and the position parity.
// Stalls: a held result stays in the output register; the back end keeps working
// on seeds and even bytes until it needs that register again.
`timescale 1ns / 1ps

module xorshift_keystream_descrambler_unit #(
    parameter int unsigned QUEUE_DEPTH = xkd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        action,
    input  logic [31:0] seed_word,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_valid,
    input  logic        out_ready
);

    xkd_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_ready;

    // Accept and classify beats; mask the seed on the way in
    xkd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .seed_word (seed_word),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    // Seed, discard and descramble; hold the result beat
    xkd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

// File: rtl/core/xkd_front.sv
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on xkd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xkd_front #(
    parameter int unsigned QUEUE_DEPTH = xkd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          action,
    input  logic [31:0]   seed_word,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic          in_valid,
    output logic          in_ready,
    output xkd_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    xkd_pkg::cmd_t q_mem [QUEUE_DEPTH];
    xkd_pkg::cmd_t entry;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    // Classify the incoming beat
    always_comb
    begin
        entry.is_seed   = (action == xkd_pkg::ACT_SEED);
        entry.seed      = seed_word ^ xkd_pkg::SEED_MASK;
        entry.data_byte = in_byte;
        entry.last      = in_last;
    end

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    `XKD_ASSERT(a_cnt_range, count_reg <= CNT_W'(QUEUE_DEPTH))
    `XKD_ASSERT(a_ptr_meet, (wr_ptr_reg == rd_ptr_reg) |-> (count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH)))
    `XKD_ASSERT(a_cnt_track, $past(rst_n) |-> count_reg == $past(count_reg) + CNT_W'($past(push)) - CNT_W'($past(pop)))

endmodule

// File: rtl/core/xkd_keygen.sv
// Five-word xorshift keystream generator with a registered multiply output.
// Depends on xkd_pkg.
`timescale 1ns / 1ps

module xkd_keygen (
    input  logic               clk,
    input  logic               rst_n,
    input  xkd_pkg::gen_ctrl_t ctrl,
    input  logic [31:0]        seed,
    output logic [31:0]        key
);

    logic [31:0] w_reg  [xkd_pkg::GEN_WORDS];
    logic [31:0] w_next [xkd_pkg::GEN_WORDS];
    logic [31:0] key_reg;
    logic [31:0] u;
    logic [31:0] new_w4;
    logic [31:0] mult;

    always_comb
    begin
        u      = w_reg[0] ^ (w_reg[0] >> xkd_pkg::SH_U_R);
        new_w4 = u ^ (u << xkd_pkg::SH_U_L) ^ w_reg[4] ^ (w_reg[4] << xkd_pkg::SH_W_L);
        mult   = {w_reg[2][30:0], 1'b1};

        w_next = w_reg;
        if (ctrl.load)
        begin
            // Expand the masked seed into the five words
            w_next[0] = seed;
            w_next[1] = (seed >> 1) + xkd_pkg::EXP_C1;
            w_next[2] = (seed >> 3) + xkd_pkg::EXP_C2;
            w_next[3] = (seed >> 5) + xkd_pkg::EXP_C3;
            w_next[4] = (seed >> 7) + xkd_pkg::EXP_C4;
        end
        else if (ctrl.step)
        begin
            // Shift down and append the new word
            w_next[0] = w_reg[1];
            w_next[1] = w_reg[2];
            w_next[2] = w_reg[3];
            w_next[3] = w_reg[4];
            w_next[4] = new_w4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < xkd_pkg::GEN_WORDS; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            w_reg <= w_next;
        end
    end

    // Output word, low 32 bits of the product, registered on each step
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            key_reg <= new_w4 * mult;
        end
    end

    assign key = key_reg;

endmodule

// File: rtl/core/xkd_back.sv
// Back end: sequences seeding and discards, descrambles data bytes, holds the result beat.
// Depends on xkd_pkg, xkd_keygen and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xkd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  xkd_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic          out_valid,
    input  logic          out_ready
);

    xkd_pkg::back_state_t state_reg, state_next;
    xkd_pkg::gen_ctrl_t   gen_ctrl;

    logic [31:0]               key;
    logic [xkd_pkg::SKIP_W-1:0] skip_reg, skip_next;
    logic [xkd_pkg::SKIP_W-1:0] draw_cnt;
    logic                      odd_reg, odd_next;
    logic [7:0]                hold_byte_reg;
    logic                      hold_last_reg;
    logic [7:0]                out_byte_reg, out_byte_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_valid_reg;
    logic                      out_free, out_load, pop;

    xkd_keygen u_keygen (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (gen_ctrl),
        .seed  (cmd.seed),
        .key   (key)
    );

    assign draw_cnt = key[xkd_pkg::SKIP_W-1:0];
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = cmd_valid && cmd_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xkd_pkg::ST_IDLE:
            begin
                if (pop && cmd.is_seed)
                begin
                    state_next = xkd_pkg::ST_SEED_DRAW;
                end
                else if (pop && !odd_reg)
                begin
                    state_next = xkd_pkg::ST_DATA_XOR;
                end
            end
            xkd_pkg::ST_SEED_DRAW:
            begin
                state_next = xkd_pkg::ST_SEED_CNT;
            end
            xkd_pkg::ST_SEED_CNT:
            begin
                if (draw_cnt > xkd_pkg::SKIP_W'(1))
                begin
                    state_next = xkd_pkg::ST_SKIP;
                end
                else
                begin
                    state_next = xkd_pkg::ST_IDLE;
                end
            end
            xkd_pkg::ST_SKIP:
            begin
                if (skip_reg == xkd_pkg::SKIP_W'(1))
                begin
                    state_next = xkd_pkg::ST_IDLE;
                end
            end
            xkd_pkg::ST_DATA_XOR:
            begin
                if (out_free)
                begin
                    state_next = xkd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xkd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd_ready     = 1'b0;
        gen_ctrl      = '0;
        out_load      = 1'b0;
        out_byte_next = cmd.data_byte;
        out_last_next = cmd.last;
        skip_next     = skip_reg;
        unique case (state_reg)
            xkd_pkg::ST_IDLE:
            begin
                // An odd byte goes straight to the output slot, so it needs the slot
                cmd_ready     = cmd.is_seed || !odd_reg || out_free;
                gen_ctrl.load = pop && cmd.is_seed;
                gen_ctrl.step = pop && !cmd.is_seed && !odd_reg;
                out_load      = pop && !cmd.is_seed && odd_reg;
            end
            xkd_pkg::ST_SEED_DRAW:
            begin
                gen_ctrl.step = 1'b1;
            end
            xkd_pkg::ST_SEED_CNT:
            begin
                // First discard happens here; the rest in ST_SKIP
                gen_ctrl.step = (draw_cnt != '0);
                skip_next     = draw_cnt - xkd_pkg::SKIP_W'(1);
            end
            xkd_pkg::ST_SKIP:
            begin
                gen_ctrl.step = 1'b1;
                skip_next     = skip_reg - xkd_pkg::SKIP_W'(1);
            end
            xkd_pkg::ST_DATA_XOR:
            begin
                out_load      = out_free;
                out_byte_next = hold_byte_reg ^ key[7:0];
                out_last_next = hold_last_reg;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        odd_next = odd_reg;
        if (pop)
        begin
            odd_next = cmd.is_seed ? 1'b0 : !odd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xkd_pkg::ST_IDLE;
            odd_reg       <= 1'b0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            odd_reg   <= odd_next;
            skip_reg  <= skip_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !cmd.is_seed)
        begin
            hold_byte_reg <= cmd.data_byte;
            hold_last_reg <= cmd.last;
        end
        if (out_load)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    `XKD_ASSERT(a_draw_then_cnt, (state_reg == xkd_pkg::ST_SEED_DRAW) |=> (state_reg == xkd_pkg::ST_SEED_CNT))
    `XKD_ASSERT(a_skip_nonzero, (state_reg == xkd_pkg::ST_SKIP) |-> (skip_reg != '0))
    `XKD_ASSERT(a_seed_clears_odd, (pop && cmd.is_seed) |=> !odd_reg)

endmodule

// File: dv/testbench.sv
// Self-checking testbench for xorshift_keystream_descrambler_unit.
// Depends on xkd_pkg (action codes, seed mask, expansion constants, shift amounts)
// and the unit's RTL; drives seed and data beats and checks every descrambled byte.
`timescale 1ns / 1ps

module testbench;

    // Stop the run if this many cycles pass with no beat moving on either channel
    localparam int unsigned STALL_LIMIT = 600;
    // Hold the receiver off this long once, so the unit fills up and stalls its input
    localparam int unsigned HOLD_OFF_CYCLES = 120;
    // Cycles to watch for stray results after the last expected one
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_ITEMS = 450;

    // One row of the directed stimulus; exp_* are used only when pinned is set
    typedef struct packed {
        logic        act;
        logic [31:0] seed;
        logic [7:0]  data;
        logic        last;
        logic        pinned;
        logic [7:0]  exp_data;
        logic        exp_last;
    } stim_row_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } plain_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        action = xkd_pkg::ACT_SEED;
    logic [31:0] seed_word = '0;
    logic [7:0]  in_byte = '0;
    logic        in_last = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        out_valid;
    logic        out_ready = 1'b0;

    // Predictor state: the five generator words and the byte position parity
    logic [31:0] gen_w [xkd_pkg::GEN_WORDS];
    logic        odd_pos;

    plain_byte_t plain_q [$];
    int unsigned errors = 0;
    int unsigned beats_in = 0;
    int unsigned idle_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    // Set for a stretch of the random part: neither side idles then
    bit          steady = 1'b0;

    // Directed part. Pinned rows are plain to read off: data before any seed runs on
    // all-zero generator words, so the keystream is zero and bytes pass through;
    // odd positions always pass through. The rest come from the predictor.
    stim_row_t directed_rows [18] = '{
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'hff, 1'b1, 1'b1, 8'hff, 1'b1},
        '{xkd_pkg::ACT_DATA, 32'hffff_ffff, 8'ha5, 1'b0, 1'b1, 8'ha5, 1'b0},
        '{xkd_pkg::ACT_SEED, xkd_pkg::SEED_MASK, 8'hff, 1'b1, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'hffff_ffff, 8'hff, 1'b0, 1'b1, 8'hff, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'h3c, 1'b0, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_SEED, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_SEED, 32'hffff_ffff, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{xkd_pkg::ACT_SEED, 32'hdead_beef, 8'h77, 1'b1, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_SEED, 32'h1234_5678, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'h5a, 1'b0, 1'b0, 8'h00, 1'b0},
        '{xkd_pkg::ACT_DATA, 32'h0000_0000, 8'h81, 1'b1, 1'b1, 8'h81, 1'b1}
    };

    xorshift_keystream_descrambler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .seed_word (seed_word),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the generator by one step and return the keystream word
    function automatic logic [31:0] keystream_step();
        logic [31:0] t;
        logic [31:0] u;
        logic [31:0] w4;
        t = gen_w[2];
        u = gen_w[0] ^ (gen_w[0] >> xkd_pkg::SH_U_R);
        w4 = gen_w[4];
        gen_w[0] = gen_w[1];
        gen_w[1] = gen_w[2];
        gen_w[2] = gen_w[3];
        gen_w[3] = w4;
        gen_w[4] = u ^ (u << xkd_pkg::SH_U_L) ^ w4 ^ (w4 << xkd_pkg::SH_W_L);
        return gen_w[4] * {t[30:0], 1'b1};
    endfunction

    // Expand a trailer word into the generator and burn the discard count
    function automatic void keystream_reseed(input logic [31:0] trailer);
        logic [31:0] s;
        logic [31:0] first;
        logic [3:0]  discard;
        s = trailer ^ xkd_pkg::SEED_MASK;
        gen_w[0] = s;
        gen_w[1] = (s >> 1) + xkd_pkg::EXP_C1;
        gen_w[2] = (s >> 3) + xkd_pkg::EXP_C2;
        gen_w[3] = (s >> 5) + xkd_pkg::EXP_C3;
        gen_w[4] = (s >> 7) + xkd_pkg::EXP_C4;
        first = keystream_step();
        discard = first[xkd_pkg::SKIP_W-1:0];
        for (int i = 0; i < discard; i++)
            void'(keystream_step());
        odd_pos = 1'b0;
    endfunction

    // Even positions take the low keystream byte, odd positions pass through
    function automatic logic [7:0] descramble_byte(input logic [7:0] data);
        logic [31:0] ks;
        logic [7:0]  plain;
        plain = data;
        if (!odd_pos)
        begin
            ks = keystream_step();
            plain = data ^ ks[7:0];
        end
        odd_pos = ~odd_pos;
        return plain;
    endfunction

    // Draw an idle gap: about 7 in 100 beats wait, one in ten of those with a longer
    // gap that can span a seed expansion
    function automatic int unsigned idle_cycles();
        if (steady || $urandom_range(99) >= 7)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(20, 4);
        return $urandom_range(3, 1);
    endfunction

    // Offer one beat, hold it until accepted, then record what it should produce.
    // Lower valid only when a gap is taken, so valid never gets two updates in a step.
    task automatic offer_beat(input logic act, input logic [31:0] sw, input logic [7:0] data,
                              input logic last, input logic pinned,
                              input logic [7:0] exp_data, input logic exp_last);
        int unsigned gap;
        plain_byte_t want;
        logic [7:0]  predicted;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action    <= act;
        seed_word <= sw;
        in_byte   <= data;
        in_last   <= last;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        beats_in++;
        if (act == xkd_pkg::ACT_SEED)
            keystream_reseed(sw);
        else
        begin
            predicted = descramble_byte(data);
            want.data = pinned ? exp_data : predicted;
            want.last = pinned ? exp_last : last;
            plain_q.push_back(want);
        end
    endtask

    // Send a random data beat with junk in the seed field
    task automatic offer_data(input logic last);
        offer_beat(xkd_pkg::ACT_DATA, $urandom, 8'($urandom), last, 1'b0, 8'h00, 1'b0);
    endtask

    // Send a seed beat with junk in the data fields
    task automatic offer_seed();
        offer_beat(xkd_pkg::ACT_SEED, $urandom, 8'($urandom), 1'($urandom), 1'b0,
                   8'h00, 1'b0);
    endtask

    // Receiver: check each result beat against the oldest expectation, then pick
    // the next ready. The single long hold-off is counted here, apart from the sender.
    always @(posedge clk)
    begin
        plain_byte_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (plain_q.size() == 0)
                begin
                    $error("unexpected result beat: out_byte=%02h out_last=%0b",
                           out_byte, out_last);
                    errors++;
                end
                else
                begin
                    want = plain_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                        errors++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %0b, got %0b", want.last, out_last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && beats_in >= 100)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 18);
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_LIMIT)
            begin
                $display("xorshift_keystream_descrambler_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        stim_row_t   row;
        // The predictor starts from the reset state: all words zero, even position
        for (int i = 0; i < xkd_pkg::GEN_WORDS; i++)
            gen_w[i] = '0;
        odd_pos = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            offer_beat(row.act, row.seed, row.data, row.last, row.pinned,
                       row.exp_data, row.exp_last);
        end

        // Random part: mostly whole buffers (seed, then bytes with last on the final
        // one), plus stray bytes without a fresh seed and lone back-to-back seeds
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (sent >= 200 && sent < 260);
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                offer_seed();
                for (int i = 1; i <= len; i++)
                    offer_data(i == len);
                sent += len + 1;
            end
            else if (kind < 90)
            begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++)
                    offer_data(1'($urandom));
                sent += len;
            end
            else
            begin
                offer_seed();
                sent++;
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Drain: wait for every expected byte, then watch a while for strays
        while (plain_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("xorshift_keystream_descrambler_unit: match");
        else
            $display("xorshift_keystream_descrambler_unit: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/xkd_pkg.sv
rtl/core/xkd_front.sv
rtl/core/xkd_keygen.sv
rtl/core/xkd_back.sv
rtl/core/xorshift_keystream_descrambler_unit.sv
dv/testbench.sv
